FILE: rtl/core/char_ngram_counter_assert.svh
// Assertion macros for the n-gram counter.
`ifndef CHAR_NGRAM_COUNTER_ASSERT_SVH
`define CHAR_NGRAM_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CNC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/cnc_pkg.sv
`default_nettype none

package cnc_pkg;

	localparam int SYM_W        = 6;
	localparam int SYMBOL_SLOTS = 38;
	localparam int SYM_WILD     = SYMBOL_SLOTS - 1;
	localparam int SYM_SPACE    = 36;
	localparam int SYM_DIGIT0   = 26;
	localparam int SYM_BAD      = 63;
	localparam int OUT_W        = 32;
	localparam int CHAR_W       = 8;
	localparam int RADDR_W      = 16;
	localparam int CMD_W        = 2;
	localparam int LEN_W        = 2;

	typedef logic [SYM_W-1:0] sym_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_COUNT   = 2'd0,
		CMD_READ    = 2'd1,
		CMD_RESTART = 2'd2
	} cnc_cmd_t;

	// Requests from the sequencer to the counter store.
	typedef struct packed {
		logic read_req;
		logic bump_req;
	} cnc_mem_ctl_t;

	// Status back from the counter store.
	typedef struct packed {
		logic clear_busy;
		logic read_valid;
	} cnc_mem_sts_t;

	// Map a text byte to its symbol; anything not letter, digit or whitespace is bad.
	function automatic sym_t sym_of(input logic [CHAR_W-1:0] b);
		sym_t s;
		if (b >= 8'h61 && b <= 8'h7A) begin
			s = SYM_W'(b - 8'h61);
		end else if (b >= 8'h41 && b <= 8'h5A) begin
			s = SYM_W'(b - 8'h41);
		end else if (b >= 8'h30 && b <= 8'h39) begin
			s = SYM_W'(b - 8'h30 + 8'(SYM_DIGIT0));
		end else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
			s = SYM_W'(SYM_SPACE);
		end else begin
			s = SYM_W'(SYM_BAD);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cnc_count_store.sv
`default_nettype none

module cnc_count_store import cnc_pkg::*; #(
	parameter int DEPTH      = 54872,
	parameter int ADDR_W     = 16,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cnc_mem_ctl_t          ctl,
	input  wire logic [ADDR_W-1:0]     addr,
	output cnc_mem_sts_t               sts,
	output logic      [COUNT_BITS-1:0] rdata
);

	logic [COUNT_BITS-1:0] mem [DEPTH];

	logic                  clear_q;
	logic [ADDR_W-1:0]     clr_addr_q;
	logic                  bump_s1;
	logic                  read_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [COUNT_BITS-1:0] rd_data_s1;

	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [COUNT_BITS-1:0] wr_data;

	// Sweep the whole table to zero after reset, one entry a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_s1 <= 1'b0;
			read_s1 <= 1'b0;
		end else begin
			bump_s1 <= ctl.bump_req;
			read_s1 <= ctl.read_req;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
	end

	// Write back the incremented count in the cycle after its read; hold at max.
	always_comb begin
		if (clear_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = bump_s1;
			wr_addr = addr_s1;
			wr_data = (&rd_data_s1) ? rd_data_s1 : rd_data_s1 + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.read_req || ctl.bump_req) begin
			rd_data_s1 <= mem[addr];
		end
	end

	assign sts.clear_busy = clear_q;
	assign sts.read_valid = read_s1;
	assign rdata          = rd_data_s1;

endmodule

`default_nettype wire

FILE: rtl/core/char_ngram_counter.sv
// Character n-gram counter. Each request on the slave stream carries a command
// in s_tuser: count a text byte, read one counter, or restart the history.
// Bytes fold to 37 symbols (letters 0-25 case-blind, digits 26-35, whitespace
// 36); other bytes are illegal. A counted byte closes a window of ngram_length
// symbols once the history is primed; a window without illegal symbols bumps
// its exact n-gram counter, the counter with its last symbol as wildcard 37
// (lengths above one) and the total counter [37,0,..], all saturating. A read
// returns one counter on the master stream, addressed in base 38 with the
// first symbol most significant; addresses past the table answer zero.
// After reset the table is swept to zero, during which s_tready stays low;
// cfg writes are taken. The counters live in one memory with one read and
// one write port; each bump is a read followed in the next cycle by a write,
// overlapped with the next read. A counting byte is taken in ST_IDLE and then
// walks one ST_BUMP step per bump; a byte that bumps nothing stays in ST_IDLE.
// A read waits in ST_READ until the output register is free, then loads it
// through ST_RWAIT; an address past the table loads zero from ST_READ.
// Restart is handled in ST_IDLE.
// The output register lets the next request in while a result waits.
`default_nettype none

`include "char_ngram_counter_assert.svh"

module char_ngram_counter import cnc_pkg::*; #(
	parameter int MAX_NGRAM  = 3,
	parameter int COUNT_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration: ngram_length
	input  wire logic              cfg_we,
	input  wire logic [LEN_W-1:0]  cfg_wdata,
	// request stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [23:0]       s_tdata,   // char_code [7:0], read_address [23:8]
	input  wire logic [CMD_W-1:0]  s_tuser,   // command [1:0]
	// result stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [OUT_W-1:0]  m_tdata    // count_value [31:0]
);

	localparam int TABLE_DEPTH = SYMBOL_SLOTS ** MAX_NGRAM;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int HIST_N      = (MAX_NGRAM > 1) ? MAX_NGRAM - 1 : 1;
	localparam int CALC_W      = 24;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_BUMP  = 5'b00100,
		ST_READ  = 5'b01000,
		ST_RWAIT = 5'b10000
	} state_t;

	state_t               state_q;
	logic [LEN_W-1:0]     ngram_length_q;
	sym_t                 hist_q [HIST_N];
	logic [1:0]           prime_q;
	logic [ADDR_W-1:0]    bump_addr_q [3];
	logic [1:0]           bump_left_q;
	logic [RADDR_W-1:0]   rd_addr_q;
	logic                 rd_oob_q;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;

	cnc_mem_ctl_t          mem_ctl;
	cnc_mem_sts_t          mem_sts;
	logic [ADDR_W-1:0]     mem_addr;
	logic [COUNT_BITS-1:0] mem_rdata;
	logic [OUT_W-1:0]      rd_sat;

	logic [CHAR_W-1:0]  char_code;
	logic [RADDR_W-1:0] read_address;
	logic               accept;
	logic               out_free;
	logic               result_load;
	logic [2:0]         eff_len;
	sym_t               cur_sym;
	sym_t               new_sym;
	sym_t               old_sym;
	logic               window;
	logic               win_ok;
	logic [CALC_W-1:0]  prefix;
	logic [CALC_W-1:0]  exact_addr;
	logic [CALC_W-1:0]  wild_addr;
	logic [CALC_W-1:0]  total_addr;

	assign char_code    = s_tdata[7:0];
	assign read_address = s_tdata[23:8];
	assign s_tready     = (state_q == ST_IDLE);
	assign accept       = s_tvalid && s_tready;
	assign out_free     = !m_tvalid_q || m_tready;
	// Load the result register: read data back, or zero for a read past the table.
	assign result_load  = (state_q == ST_RWAIT) ||
		((state_q == ST_READ) && out_free && rd_oob_q);

	// Length zero acts as one, lengths past MAX_NGRAM clamp to it.
	always_comb begin
		if (ngram_length_q == '0) begin
			eff_len = 3'd1;
		end else if (32'(ngram_length_q) > MAX_NGRAM) begin
			eff_len = 3'(MAX_NGRAM);
		end else begin
			eff_len = 3'(ngram_length_q);
		end
	end

	// Newest history symbol sits at the top slot; the one before it below.
	assign cur_sym = sym_of(char_code);
	assign new_sym = hist_q[HIST_N-1];
	assign old_sym = hist_q[(HIST_N >= 2) ? HIST_N - 2 : 0];
	assign window  = 3'(prime_q) >= eff_len - 3'd1;

	// Build the window's base-38 addresses; an illegal symbol voids the window.
	always_comb begin
		win_ok     = 32'(cur_sym) < SYM_WILD;
		prefix     = '0;
		total_addr = CALC_W'(SYM_WILD);
		case (eff_len)
			3'd2: begin
				win_ok     = win_ok && (32'(new_sym) < SYM_WILD);
				prefix     = CALC_W'(new_sym);
				total_addr = CALC_W'(SYM_WILD * SYMBOL_SLOTS);
			end
			3'd3: begin
				win_ok     = win_ok && (32'(new_sym) < SYM_WILD) && (32'(old_sym) < SYM_WILD);
				prefix     = CALC_W'(old_sym) * CALC_W'(SYMBOL_SLOTS) + CALC_W'(new_sym);
				total_addr = CALC_W'(SYM_WILD * SYMBOL_SLOTS * SYMBOL_SLOTS);
			end
			default: begin
			end
		endcase
		exact_addr = prefix * CALC_W'(SYMBOL_SLOTS) + CALC_W'(cur_sym);
		wild_addr  = prefix * CALC_W'(SYMBOL_SLOTS) + CALC_W'(SYM_WILD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ngram_length_q <= LEN_W'(1);
		end else if (cfg_we) begin
			ngram_length_q <= cfg_wdata;
		end
	end

	// Sequencer: take one request, then walk its bumps or its read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			prime_q     <= '0;
			bump_left_q <= '0;
			m_tvalid_q  <= 1'b0;
			for (int i = 0; i < HIST_N; i++) begin
				hist_q[i] <= SYM_W'(SYM_BAD);
			end
		end else begin
			if (result_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (!mem_sts.clear_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							CMD_COUNT: begin
								// shift history, newest symbol into the top slot
								for (int i = 0; i < HIST_N - 1; i++) begin
									hist_q[i] <= hist_q[i+1];
								end
								hist_q[HIST_N-1] <= cur_sym;
								if (!window) begin
									prime_q <= prime_q + 2'd1;
								end else if (win_ok) begin
									bump_left_q <= (eff_len > 3'd1) ? 2'd3 : 2'd2;
									state_q     <= ST_BUMP;
								end
							end
							CMD_READ: begin
								state_q <= ST_READ;
							end
							CMD_RESTART: begin
								prime_q <= '0;
								for (int i = 0; i < HIST_N; i++) begin
									hist_q[i] <= SYM_W'(SYM_BAD);
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_BUMP: begin
					bump_left_q <= bump_left_q - 2'd1;
					if (bump_left_q == 2'd1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (out_free) begin
						if (rd_oob_q) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RWAIT;
						end
					end
				end
				ST_RWAIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: bump address queue, read address, result.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_addr_q <= read_address;
			rd_oob_q  <= 32'(read_address) >= TABLE_DEPTH;
			if (eff_len > 3'd1) begin
				bump_addr_q[0] <= ADDR_W'(exact_addr);
				bump_addr_q[1] <= ADDR_W'(wild_addr);
				bump_addr_q[2] <= ADDR_W'(total_addr);
			end else begin
				bump_addr_q[0] <= ADDR_W'(exact_addr);
				bump_addr_q[1] <= ADDR_W'(total_addr);
				bump_addr_q[2] <= ADDR_W'(total_addr);
			end
		end else if (state_q == ST_BUMP) begin
			bump_addr_q[0] <= bump_addr_q[1];
			bump_addr_q[1] <= bump_addr_q[2];
		end
		if (state_q == ST_READ && out_free && rd_oob_q) begin
			m_tdata_q <= '0;
		end else if (state_q == ST_RWAIT) begin
			m_tdata_q <= rd_sat;
		end
	end

	always_comb begin
		mem_ctl  = '0;
		mem_addr = bump_addr_q[0];
		case (state_q)
			ST_BUMP: begin
				mem_ctl.bump_req = 1'b1;
			end
			ST_READ: begin
				mem_ctl.read_req = out_free && !rd_oob_q;
				mem_addr         = ADDR_W'(rd_addr_q);
			end
			default: begin
			end
		endcase
	end

	// Clip wide counters to the 32-bit result.
	generate
		if (COUNT_BITS > OUT_W) begin : g_clip
			assign rd_sat = (|mem_rdata[COUNT_BITS-1:OUT_W]) ? '1 : mem_rdata[OUT_W-1:0];
		end else begin : g_ext
			assign rd_sat = OUT_W'(mem_rdata);
		end
	endgenerate

	cnc_count_store #(
		.DEPTH      (TABLE_DEPTH),
		.ADDR_W     (ADDR_W),
		.COUNT_BITS (COUNT_BITS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.addr   (mem_addr),
		.sts    (mem_sts),
		.rdata  (mem_rdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A read never lands on the entry whose write-back is in flight.
	`CNC_ASSERT_IMPL(a_no_rmw_hazard, clk, arst_n, $past(mem_ctl.bump_req) && (mem_ctl.read_req || mem_ctl.bump_req), mem_addr != $past(mem_addr), "read overlaps pending write-back")
	// No request taken while the table is still being swept.
	`CNC_ASSERT_IMPL(a_no_accept_in_clear, clk, arst_n, s_tready, !mem_sts.clear_busy, "request taken during clear")
	// No memory traffic from the sequencer during the sweep.
	`CNC_ASSERT_IMPL(a_quiet_in_clear, clk, arst_n, mem_sts.clear_busy, !(mem_ctl.read_req || mem_ctl.bump_req), "access during clear")
	// Read data only returns into a free output register, and is shown next.
	`CNC_ASSERT_NEXT(a_read_lands, clk, arst_n, mem_sts.read_valid && !m_tvalid_q, m_tvalid_q, "read result lost")

endmodule

`default_nettype wire

FILE: dv/tb_char_ngram_counter.sv
`default_nettype none

module tb_char_ngram_counter;
	import cnc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Table geometry and codes used by the predictor.
	localparam int MAX_NGRAM   = 3;
	localparam int TALLY_DEPTH = SYMBOL_SLOTS * SYMBOL_SLOTS * SYMBOL_SLOTS;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	// Cycles to let a counting request finish its bumps (at most three) before
	// the block is touched again.
	localparam int SETTLE_CYCLES = 16;
	localparam int TOUCHED_KEEP  = 48;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [LEN_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [23:0]         s_tdata = '0;   // char_code [7:0], read_address [23:8]
	logic [CMD_W-1:0]    s_tuser = '0;   // command [1:0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;        // count_value [31:0]

	// Traffic shaping: percent of cycles each side idles.
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;

	// Long receiver hold-off: the test bumps stall_req_id, the receiver counts it out.
	int stall_req_len = 0;
	int stall_req_id  = 0;
	int stall_id_seen = 0;
	int stall_left    = 0;

	// Predictor state: window length, symbol history, priming count, counter table.
	logic [LEN_W-1:0]  win_len;
	sym_t              history [MAX_NGRAM-1];
	int                primed;
	logic [OUT_W-1:0]  ngram_tally [TALLY_DEPTH];
	int                touched_addrs[$];   // recently bumped counters, good read targets
	logic [OUT_W-1:0]  expected_counts[$];

	int n_requests = 0;
	int n_results  = 0;
	int n_errors   = 0;

	char_ngram_counter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop; it must leave room for the post-reset table sweep.
	initial begin
		#2_000_000;
		$display("%0t: timeout, %0d results still expected", $time, expected_counts.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Fold a text byte to its symbol: letters case-blind, digits, whitespace.
	function automatic sym_t char_symbol(logic [7:0] c);
		logic [7:0] folded;
		folded = c | 8'h20;
		if (folded >= 8'h61 && folded <= 8'h7A) begin
			return sym_t'(folded - 8'h61);
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			return sym_t'(SYM_DIGIT0 + int'(c) - 8'h30);
		end
		if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
			return sym_t'(SYM_SPACE);
		end
		return sym_t'(SYM_BAD);
	endfunction

	// Saturating increment of one counter; remember it as a read target.
	function automatic void bump_tally(int addr);
		if (ngram_tally[addr] != '1) begin
			ngram_tally[addr] = ngram_tally[addr] + 1;
		end
		touched_addrs.push_back(addr);
		if (touched_addrs.size() > TOUCHED_KEEP) begin
			void'(touched_addrs.pop_front());
		end
	endfunction

	function automatic void restart_history();
		foreach (history[i]) begin
			history[i] = sym_t'(SYM_BAD);
		end
		primed = 0;
	endfunction

	// Advance the history by one byte; a clean window bumps exact, wildcard (lengths above one) and total counters.
	function automatic void predict_count(logic [7:0] c);
		int   depth;
		int   prefix;
		int   addr;
		sym_t cur;
		sym_t window [MAX_NGRAM];
		bit   in_window;
		bit   clean;
		depth = (win_len == 0) ? 1 : int'(win_len);
		cur = char_symbol(c);
		in_window = primed >= depth - 1;
		clean = 1'b1;
		if (in_window) begin
			for (int i = 0; i < depth - 1; i++) begin
				window[i] = history[MAX_NGRAM - depth + i];
			end
			window[depth-1] = cur;
			for (int i = 0; i < depth; i++) begin
				if (window[i] >= SYM_WILD) begin
					clean = 1'b0;
				end
			end
		end else begin
			primed++;
		end
		// newest symbol always lands in the top slot, priming or not
		history[0] = history[1];
		history[1] = cur;
		if (!in_window || !clean) begin
			return;
		end
		prefix = 0;
		for (int i = 0; i < depth - 1; i++) begin
			prefix = prefix * SYMBOL_SLOTS + int'(window[i]);
		end
		bump_tally(prefix * SYMBOL_SLOTS + int'(window[depth-1]));
		if (depth > 1) begin
			bump_tally(prefix * SYMBOL_SLOTS + SYM_WILD);
		end
		addr = SYM_WILD;
		for (int i = 1; i < depth; i++) begin
			addr = addr * SYMBOL_SLOTS;
		end
		bump_tally(addr);
	endfunction

	function automatic logic [OUT_W-1:0] predict_read(logic [RADDR_W-1:0] addr);
		return (int'(addr) < TALLY_DEPTH) ? ngram_tally[addr] : '0;
	endfunction

	// ---------------------------------------------------------------------
	// Receiver and result checker
	// ---------------------------------------------------------------------

	// Drive m_tready: honor a pending long hold-off first, otherwise idle at random.
	always @(posedge clk) begin
		if (stall_req_id != stall_id_seen) begin
			stall_id_seen <= stall_req_id;
			stall_left <= stall_req_len;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Compare each accepted result with the oldest expected counter value.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_counts.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual count_value %0d",
					$time, m_tdata);
				n_errors++;
			end else begin
				if (m_tdata !== expected_counts[0]) begin
					$display("%0t: count_value mismatch: expected %0d, actual %0d",
						$time, expected_counts[0], m_tdata);
					n_errors++;
				end
				void'(expected_counts.pop_front());
				n_results++;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Shared driver tasks
	// ---------------------------------------------------------------------

	// Offer one request, hold it until accepted, then advance the predictor.
	// s_tvalid stays high on return so back-to-back requests see no bubble.
	task automatic send_request(logic [CMD_W-1:0] cmd, logic [7:0] c, logic [RADDR_W-1:0] addr);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {addr, c};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		n_requests++;
		case (cmd)
			CMD_COUNT: begin
				predict_count(c);
			end
			CMD_READ: begin
				expected_counts.push_back(predict_read(addr));
			end
			CMD_RESTART: begin
				restart_history();
			end
			default: begin
				// unused command: no state change, no result
			end
		endcase
	endtask

	// Drop valid, wait for every expected result, then let trailing bumps finish.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (expected_counts.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the window length; only done with the block idle.
	task automatic set_ngram_length(logic [LEN_W-1:0] len);
		quiesce();
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_len = len;
	endtask

	// Mostly plausible text with a bias toward a few letters so n-grams repeat;
	// the rest is arbitrary bytes, most of them illegal.
	function automatic logic [7:0] pick_text_byte();
		int r;
		logic [7:0] c;
		r = $urandom_range(99);
		if (r < 40) begin
			c = 8'h61 + 8'($urandom_range(4));
		end else if (r < 65) begin
			c = 8'h61 + 8'($urandom_range(25));
		end else if (r < 75) begin
			return 8'h30 + 8'($urandom_range(9));
		end else if (r < 85) begin
			return $urandom_range(1) ? 8'h20 : 8'h09 + 8'($urandom_range(4));
		end else begin
			return 8'($urandom_range(255));
		end
		if ($urandom_range(1)) begin
			c[5] = 1'b0;   // upper case
		end
		return c;
	endfunction

	// Mostly counters known to be live, some anywhere in the table, some past it.
	function automatic logic [RADDR_W-1:0] pick_read_address();
		int r;
		r = $urandom_range(99);
		if (r < 60 && touched_addrs.size() > 0) begin
			return RADDR_W'(touched_addrs[$urandom_range(touched_addrs.size() - 1)]);
		end
		if (r < 85) begin
			return RADDR_W'($urandom_range(TALLY_DEPTH - 1));
		end
		return RADDR_W'($urandom_range(16'hFFFF));
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Every symbol class and its edges, illegal bytes, both byte extremes, reads at
	// the table's start, end and past it, the unused command and a restart.
	// Length zero is written so it has to behave as length one.
	task automatic test_char_classes();
		logic [7:0] probe_chars [10] = '{8'h41, 8'h7A, 8'h30, 8'h39, 8'h20,
			8'h0D, 8'h00, 8'hFF, 8'h40, 8'h5B};
		logic [RADDR_W-1:0] probe_addrs [7] = '{16'd0, 16'd25, 16'd36, 16'd37,
			16'(TALLY_DEPTH - 1), 16'(TALLY_DEPTH), 16'hFFFF};
		set_ngram_length(2'd0);
		foreach (probe_chars[i]) begin
			send_request(CMD_COUNT, probe_chars[i], 16'($urandom_range(16'hFFFF)));
		end
		foreach (probe_addrs[i]) begin
			send_request(CMD_READ, 8'($urandom_range(255)), probe_addrs[i]);
		end
		send_request(CMD_UNUSED, 8'h61, 16'd0);
		send_request(CMD_RESTART, 8'hFF, 16'hFFFF);
	endtask

	// Change the length mid-stream without a restart: priming carries on to the
	// new length and the history keeps its symbols.
	task automatic test_length_switch();
		set_ngram_length(2'd1);
		send_request(CMD_COUNT, 8'h71, 16'd0);                   // q
		set_ngram_length(2'd3);
		send_request(CMD_COUNT, 8'h63, 16'd0);                   // c
		send_request(CMD_COUNT, 8'h41, 16'd0);                   // A
		send_request(CMD_COUNT, 8'h74, 16'd0);                   // t
		send_request(CMD_READ, 8'h00,                            // "cat"
			16'(2 * SYMBOL_SLOTS * SYMBOL_SLOTS + 19));
		send_request(CMD_READ, 8'h00,                            // three-symbol total
			16'(SYM_WILD * SYMBOL_SLOTS * SYMBOL_SLOTS));
		set_ngram_length(2'd2);
		send_request(CMD_COUNT, 8'h53, 16'd0);                   // S closes "ts" at once
		send_request(CMD_READ, 8'h00, 16'(19 * SYMBOL_SLOTS + 18));
		send_request(CMD_READ, 8'h00, 16'(19 * SYMBOL_SLOTS + SYM_WILD));
	endtask

	// Random traffic at one window length: mostly counted text, reads of live
	// counters, plus restarts and the unused command as noise.
	task automatic test_random_text(int n_items, logic [LEN_W-1:0] len);
		int r;
		set_ngram_length(len);
		if ($urandom_range(1)) begin
			send_request(CMD_RESTART, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)));
		end
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < 68) begin
				send_request(CMD_COUNT, pick_text_byte(), 16'($urandom_range(16'hFFFF)));
			end else if (r < 90) begin
				send_request(CMD_READ, 8'($urandom_range(255)), pick_read_address());
			end else if (r < 97) begin
				send_request(CMD_RESTART, 8'($urandom_range(255)),
					16'($urandom_range(16'hFFFF)));
			end else begin
				send_request(CMD_UNUSED, 8'($urandom_range(255)),
					16'($urandom_range(16'hFFFF)));
			end
		end
	endtask

	// Hold the receiver off for a long stretch while reads keep coming, so the
	// output register fills and the block has to stall its input.
	task automatic test_backpressure();
		quiesce();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		stall_req_len = 400;
		stall_req_id++;
		for (int i = 0; i < 60; i++) begin
			if ($urandom_range(3) == 0) begin
				send_request(CMD_COUNT, pick_text_byte(), 16'($urandom_range(16'hFFFF)));
			end else begin
				send_request(CMD_READ, 8'($urandom_range(255)), pick_read_address());
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Run
	// ---------------------------------------------------------------------

	initial begin
		win_len = 2'd1;
		restart_history();
		foreach (ngram_tally[i]) begin
			ngram_tally[i] = '0;
		end

		// Hold reset, then release it; the block then sweeps its table before
		// taking any request.
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Sender idles lightly, receiver heavily.
		src_idle_pct = 14;
		sink_idle_pct = 48;
		test_char_classes();
		test_length_switch();
		test_random_text(200, 2'd2);
		test_random_text(200, 2'd3);

		// Swap: sender idles heavily, receiver lightly.
		src_idle_pct = 48;
		sink_idle_pct = 14;
		test_random_text(150, 2'd0);
		test_random_text(150, 2'd1);

		test_backpressure();

		// Full rate on both sides.
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_text(200, 2'd3);
		test_random_text(140, 2'd2);

		quiesce();
		$display("Run covered %0d requests and %0d counter reads over lengths 0 to 3,",
			n_requests, n_results);
		$display("with idle and stall on both sides and a long receiver hold-off.");
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
